FILE: rtl/core/sss_pkg.sv
// Shared types and constants for the substring search statistics core.
`timescale 1ns / 1ps
`default_nettype none
package sss_pkg;

  localparam int MAX_PATTERN = 16;
  localparam int MAX_TEXT    = 65535;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 64;

  // register index, taken from paddr[4:3]
  localparam logic [1:0] REG_PATTERN_LENGTH = 2'd0;
  localparam logic [1:0] REG_BYTES_LOW      = 2'd1;
  localparam logic [1:0] REG_BYTES_HIGH     = 2'd2;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       is_last;
  } text_item_t;

  typedef struct packed {
    logic        found;
    logic [15:0] first_index;
    logic [15:0] last_index;
    logic [16:0] match_count;
    logic [15:0] text_length;
  } result_item_t;

endpackage
`default_nettype wire

FILE: rtl/core/substring_search_stats_core.sv
// Streaming substring search core with match statistics and APB register port.
//
// Haystack bytes enter one per cycle on the text channel and are compared in parallel
// against the needle (up to 16 bytes, set at 0x00 length, 0x08 bytes 0-7, 0x10 bytes
// 8-15). A single compare of the 16-byte window against the
// needle sits between the search state registers and the result register. The byte
// marked last produces one result item on the following cycle; other bytes produce
// none. A result waiting in the output register does not block new bytes unless a
// second last byte arrives before it is taken. Bytes beyond 65535 in one search are
// ignored. Write registers only while the core is idle.
`timescale 1ns / 1ps
`default_nettype none
module substring_search_stats_core (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       text_valid,
  output logic                            text_ready,
  input  wire sss_pkg::text_item_t        text,
  output logic                            result_valid,
  input  wire logic                       result_ready,
  output sss_pkg::result_item_t           result,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [sss_pkg::ADDR_W-1:0] paddr,
  input  wire logic [sss_pkg::DATA_W-1:0] pwdata,
  output logic [sss_pkg::DATA_W-1:0]      prdata,
  output logic                            pready
);
  import sss_pkg::*;

  logic [4:0]  pattern_length;
  logic [63:0] pattern_bytes_low;
  logic [63:0] pattern_bytes_high;

  logic [7:0]  window [MAX_PATTERN];
  logic [15:0] byte_position;
  logic [16:0] matches_seen;
  logic [15:0] first_start;
  logic [15:0] latest_start;
  logic        any_match;
  logic [16:0] next_free_start;

  logic [7:0]  window_next [MAX_PATTERN];
  logic [7:0]  needle [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] byte_eq;
  logic [4:0]  nlen;
  logic        take;
  logic        hit;
  logic        counted;
  logic [15:0] byte_position_next;
  logic [15:0] match_start;
  logic [16:0] matches_seen_next;
  logic [15:0] first_start_next;
  logic [15:0] latest_start_next;
  logic        any_match_next;
  logic [16:0] next_free_start_next;
  logic        accept;
  logic        cfg_write;
  result_item_t result_next;

  assign pready     = 1'b1;
  assign cfg_write  = psel && penable && pwrite && pready;
  // only a last byte needs the result register free
  assign text_ready = !(result_valid && !result_ready && text.is_last);
  assign accept     = text_valid && text_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length     <= '0;
      pattern_bytes_low  <= '0;
      pattern_bytes_high <= '0;
    end else if (cfg_write) begin
      case (paddr[4:3])
        REG_PATTERN_LENGTH: pattern_length     <= pwdata[4:0];
        REG_BYTES_LOW:      pattern_bytes_low  <= pwdata;
        REG_BYTES_HIGH:     pattern_bytes_high <= pwdata;
        default:            ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:3])
      REG_PATTERN_LENGTH: prdata = {59'd0, pattern_length};
      REG_BYTES_LOW:      prdata = pattern_bytes_low;
      REG_BYTES_HIGH:     prdata = pattern_bytes_high;
      default:            prdata = '0;
    endcase
  end

  assign nlen = (pattern_length > 5'(MAX_PATTERN)) ? 5'(MAX_PATTERN) : pattern_length;
  assign take = byte_position != 16'(MAX_TEXT);

  always_comb begin
    window_next[0] = text.text_byte;
    for (int j = 1; j < MAX_PATTERN; j++) begin
      window_next[j] = window[j-1];
    end
    for (int k = 0; k < 8; k++) begin
      needle[k]     = pattern_bytes_low[8*k +: 8];
      needle[k + 8] = pattern_bytes_high[8*k +: 8];
    end
  end

  // needle byte k lines up with the byte taken len-1-k bytes before the current one
  always_comb begin
    for (int k = 0; k < MAX_PATTERN; k++) begin
      byte_eq[k] = (5'(k) >= nlen) ||
                   (needle[k] == window_next[4'(nlen - 5'd1 - 5'(k))]);
    end
  end

  always_comb begin
    byte_position_next   = take ? byte_position + 16'd1 : byte_position;
    match_start          = byte_position_next - {11'd0, nlen};
    hit                  = take && (nlen != 5'd0) && (byte_position_next >= {11'd0, nlen}) &&
                           (&byte_eq);
    counted              = hit && ({1'b0, match_start} >= next_free_start);
    any_match_next       = any_match || hit;
    first_start_next     = (hit && !any_match) ? match_start : first_start;
    latest_start_next    = hit ? match_start : latest_start;
    matches_seen_next    = counted ? matches_seen + 17'd1 : matches_seen;
    next_free_start_next = counted ? {1'b0, byte_position_next} : next_free_start;

    result_next.text_length = byte_position_next;
    if (nlen == 5'd0) begin
      result_next.found       = 1'b1;
      result_next.first_index = '0;
      result_next.last_index  = byte_position_next;
      result_next.match_count = {1'b0, byte_position_next} + 17'd1;
    end else if (any_match_next) begin
      result_next.found       = 1'b1;
      result_next.first_index = first_start_next;
      result_next.last_index  = latest_start_next;
      result_next.match_count = matches_seen_next;
    end else begin
      result_next.found       = 1'b0;
      result_next.first_index = '0;
      result_next.last_index  = '0;
      result_next.match_count = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && take) begin
      for (int j = 0; j < MAX_PATTERN; j++) begin
        window[j] <= window_next[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= '0;
      matches_seen    <= '0;
      first_start     <= '0;
      latest_start    <= '0;
      any_match       <= 1'b0;
      next_free_start <= '0;
    end else if (accept) begin
      if (text.is_last) begin
        byte_position   <= '0;
        matches_seen    <= '0;
        first_start     <= '0;
        latest_start    <= '0;
        any_match       <= 1'b0;
        next_free_start <= '0;
      end else begin
        byte_position   <= byte_position_next;
        matches_seen    <= matches_seen_next;
        first_start     <= first_start_next;
        latest_start    <= latest_start_next;
        any_match       <= any_match_next;
        next_free_start <= next_free_start_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept && text.is_last) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && text.is_last) begin
      result <= result_next;
    end
  end

`ifndef ASSERT_OFF
  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    (accept && text.is_last) |=> result_valid)
    else $error("no result after last item");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (rst)
    (accept && !text.is_last && !result_valid) |=> !result_valid)
    else $error("result without last item");

  a_count_needs_match: assert property (@(posedge clk) disable iff (rst)
    !any_match |-> (matches_seen == 17'd0))
    else $error("matches counted without any match");

  a_free_start_bound: assert property (@(posedge clk) disable iff (rst)
    next_free_start <= {1'b0, byte_position})
    else $error("next free start beyond position");

  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.found) |->
      (result.first_index == 16'd0 && result.last_index == 16'd0 &&
       result.match_count == 17'd0))
    else $error("not-found result carries nonzero stats");
`endif

endmodule
`default_nettype wire
